// ----- sv/ccc_pkg.sv -----
// Calendar clock counter: shared field widths and the calendar state type.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ccc_pkg;

  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned PrescW = 8;

  // Input transaction kinds carried in func.
  localparam logic FuncTick = 1'b0;
  localparam logic FuncSet  = 1'b1;

  // Time and date as held by the counter and shown on the result channel.
  typedef struct packed {
    logic [SecW-1:0]  seconds;
    logic [MinW-1:0]  minutes;
    logic [HourW-1:0] hours;
    logic [DayW-1:0]  day;
    logic [WdayW-1:0] weekday;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } cal_state_t;

endpackage

// ----- sv/ccc_if.sv -----
// Calendar clock counter: valid/ready channel interfaces (input, result, config).
// Depends on ccc_pkg for field widths.
`timescale 1ns / 1ps

interface ccc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [ccc_pkg::SecW-1:0]       set_seconds;
  logic [ccc_pkg::MinW-1:0]       set_minutes;
  logic [ccc_pkg::HourW-1:0]      set_hours;
  logic [ccc_pkg::DayW-1:0]       set_day;
  logic [ccc_pkg::WdayW-1:0]      set_weekday;
  logic [ccc_pkg::MonW-1:0]       set_month;
  logic [ccc_pkg::YearW-1:0]      set_year;

  modport source (output valid, func, set_seconds, set_minutes, set_hours, set_day,
                  set_weekday, set_month, set_year, input ready);
  modport sink (input valid, func, set_seconds, set_minutes, set_hours, set_day,
                set_weekday, set_month, set_year, output ready);
endinterface

interface ccc_out_if;
  logic                           valid;
  logic                           ready;
  logic [ccc_pkg::SecW-1:0]       seconds_now;
  logic [ccc_pkg::MinW-1:0]       minutes_now;
  logic [ccc_pkg::HourW-1:0]      hours_now;
  logic [ccc_pkg::DayW-1:0]       day_now;
  logic [ccc_pkg::WdayW-1:0]      weekday_now;
  logic [ccc_pkg::MonW-1:0]       month_now;
  logic [ccc_pkg::YearW-1:0]      year_now;
  logic                           second_elapsed;

  modport source (output valid, seconds_now, minutes_now, hours_now, day_now,
                  weekday_now, month_now, year_now, second_elapsed, input ready);
  modport sink (input valid, seconds_now, minutes_now, hours_now, day_now,
                weekday_now, month_now, year_now, second_elapsed, output ready);
endinterface

interface ccc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ccc_pkg::PrescW-1:0]     ticks_per_second;

  modport source (output valid, ticks_per_second, input ready);
  modport sink (input valid, ticks_per_second, output ready);
endinterface

// ----- sv/ccc_advance.sv -----
// Calendar clock counter: combinational one-second advance of time and date.
// Depends on ccc_pkg (cal_state_t).
`timescale 1ns / 1ps

module ccc_advance (
  input  ccc_pkg::cal_state_t state_i,
  output ccc_pkg::cal_state_t state_o
);

  localparam logic [ccc_pkg::SecW-1:0]  SecTop  = 6'd59;
  localparam logic [ccc_pkg::MinW-1:0]  MinTop  = 6'd59;
  localparam logic [ccc_pkg::HourW-1:0] HourTop = 5'd23;
  localparam logic [ccc_pkg::WdayW-1:0] WdayTop = 3'd7;
  localparam logic [ccc_pkg::MonW-1:0]  MonTop  = 4'd12;
  localparam logic [ccc_pkg::YearW-1:0] YearMax = '1;
  // Multiplicative inverse of 25 mod 2^16; y is a multiple of 25 exactly
  // when y * Inv25 (mod 2^16) does not exceed (2^16 - 1) / 25.
  localparam logic [ccc_pkg::YearW-1:0] Inv25    = 16'h5C29;
  localparam logic [ccc_pkg::YearW-1:0] Div25Max = 16'd2621;

  logic [ccc_pkg::YearW-1:0] div25_prod;
  logic                      div25;
  logic                      leap;
  logic [ccc_pkg::DayW-1:0]  month_len;
  logic                      day_roll;
  ccc_pkg::cal_state_t       nxt;

  // Gregorian rule: divisible by 4, and not by 100 unless by 400.
  assign div25_prod = ccc_pkg::YearW'(state_i.year * Inv25);
  assign div25      = (div25_prod <= Div25Max);
  assign leap       = (state_i.year[1:0] == 2'b00) && (!div25 || state_i.year[3:0] == 4'h0);

  always_comb begin
    case (state_i.month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   month_len = 5'd30;
      4'd2:                                      month_len = leap ? 5'd29 : 5'd28;
      default:                                   month_len = '0;
    endcase
  end

  always_comb begin
    nxt      = state_i;
    day_roll = 1'b0;
    // Time of day: carry ripples seconds -> minutes -> hours -> date.
    if (state_i.seconds < SecTop) begin
      nxt.seconds = state_i.seconds + 6'd1;
    end else begin
      nxt.seconds = '0;
      if (state_i.minutes < MinTop) begin
        nxt.minutes = state_i.minutes + 6'd1;
      end else begin
        nxt.minutes = '0;
        if (state_i.hours < HourTop) begin
          nxt.hours = state_i.hours + 5'd1;
        end else begin
          nxt.hours = '0;
          day_roll  = 1'b1;
        end
      end
    end

    // Date: weekday zero means unset, leave the date alone.
    if (day_roll && state_i.weekday != '0) begin
      nxt.weekday = (state_i.weekday >= WdayTop) ? 3'd1 : state_i.weekday + 3'd1;
      if (state_i.month == '0) begin
        nxt.day = state_i.day;
      end else if (state_i.month > MonTop) begin
        nxt.day = '0;
      end else if (state_i.day >= month_len) begin
        nxt.day = 5'd1;
        if (state_i.month >= MonTop) begin
          nxt.month = 4'd1;
          if (state_i.year != '0 && state_i.year != YearMax) begin
            nxt.year = state_i.year + 16'd1;
          end
        end else begin
          nxt.month = state_i.month + 4'd1;
        end
      end else begin
        nxt.day = state_i.day + 5'd1;
      end
    end
  end

  assign state_o = nxt;

endmodule

// ----- sv/calendar_clock_counter_top.sv -----
// Calendar clock counter top level: prescaler, time/date registers, channels.
// Depends on ccc_pkg, ccc_if (channel interfaces) and ccc_advance.
`timescale 1ns / 1ps

// Real-time clock with calendar. Each input transaction is either a tick
// (func = 0) or a set command (func = 1) that loads time and date as given,
// clears the prescaler and reports second_elapsed = 0. Every ticks_per_second
// ticks count one second (a value of 0 acts as 1); the second rolls seconds,
// minutes and hours, and the midnight wrap advances weekday, day, month and
// year using Gregorian month lengths. Weekday 0 means the date is unset and
// midnight leaves it alone; month 0 freezes the day; a month above 12 clears
// the day at midnight; the year holds at 0 and at 65535. Every input
// transaction gives exactly one result transaction carrying the time and date
// after it. Throughput is one transaction per clock unless the result stalls;
// the result appears in the cycle after acceptance, from a single registered
// pass through the seconds-to-year carry chain and the leap-year multiply.
// A new input is taken whenever the result register is empty or being drained
// in the same cycle. ticks_per_second resets to 1 and is written through the
// config channel, which is always ready; write it only while the block is idle.
module calendar_clock_counter_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  ccc_cfg_if.sink         cfg_i,
  ccc_in_if.sink          in_i,
  ccc_out_if.source       out_o
);

  logic [ccc_pkg::PrescW-1:0] tps_q;
  logic [ccc_pkg::PrescW-1:0] presc_q, presc_d;
  logic [ccc_pkg::PrescW-1:0] limit;
  ccc_pkg::cal_state_t        state_q, state_d;
  ccc_pkg::cal_state_t        adv_state;
  ccc_pkg::cal_state_t        set_state;
  logic                       out_valid_q, out_valid_d;
  logic                       elapsed_q, elapsed_d;
  logic                       in_accept;
  logic                       sec_tick;

  // Config register is always writable.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= 8'd1;
    end else if (cfg_i.valid) begin
      tps_q <= cfg_i.ticks_per_second;
    end
  end

  // Take a new transaction when the result slot is free or drains this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  // Prescaler: a second elapses once the count reaches ticks_per_second - 1.
  assign limit    = (tps_q == '0) ? '0 : tps_q - 8'd1;
  assign sec_tick = (presc_q >= limit);

  assign set_state = '{seconds: in_i.set_seconds, minutes: in_i.set_minutes,
                       hours:   in_i.set_hours,   day:     in_i.set_day,
                       weekday: in_i.set_weekday, month:   in_i.set_month,
                       year:    in_i.set_year};

  ccc_advance u_advance (
    .state_i (state_q),
    .state_o (adv_state)
  );

  always_comb begin
    state_d     = state_q;
    presc_d     = presc_q;
    elapsed_d   = elapsed_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_accept) begin
      out_valid_d = 1'b1;
      if (in_i.func == ccc_pkg::FuncSet) begin
        // Load everything as given, even out-of-range values.
        state_d   = set_state;
        presc_d   = '0;
        elapsed_d = 1'b0;
      end else if (sec_tick) begin
        state_d   = adv_state;
        presc_d   = '0;
        elapsed_d = 1'b1;
      end else begin
        presc_d   = presc_q + 8'd1;
        elapsed_d = 1'b0;
      end
    end
  end

  // The time/date registers double as the result register: they change only
  // on acceptance, which happens only when the previous result is gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      presc_q     <= '0;
      elapsed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      presc_q     <= presc_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.seconds_now    = state_q.seconds;
  assign out_o.minutes_now    = state_q.minutes;
  assign out_o.hours_now      = state_q.hours;
  assign out_o.day_now        = state_q.day;
  assign out_o.weekday_now    = state_q.weekday;
  assign out_o.month_now      = state_q.month;
  assign out_o.year_now       = state_q.year;
  assign out_o.second_elapsed = elapsed_q;

  // A reported second always leaves the prescaler cleared.
  a_elapsed_clears_presc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && elapsed_q |-> presc_q == '0)
    else $error("second_elapsed without cleared prescaler");

  // A set command is echoed as loaded, with no elapsed second.
  a_set_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.func == ccc_pkg::FuncSet |=> out_valid_q && !elapsed_q
      && state_q == $past(set_state) && presc_q == '0)
    else $error("set command not loaded");

  // A waiting result holds the calendar state.
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(state_q) && $stable(presc_q))
    else $error("state changed while result stalled");

  // A tick that does not reach the second boundary leaves time untouched.
  a_no_tick_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.func == ccc_pkg::FuncTick && !sec_tick
      |=> $stable(state_q) && !elapsed_q)
    else $error("time changed without a second");

endmodule
